>>> rtl/cas_pkg.sv
// Package for the call argument scanner: widths, scan modes, record kinds,
// character codes, character-class functions and the result record type.
// Used by rtl/call_argument_scanner.sv and rtl/cas_checker.sv.
package cas_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int DEPTH_BITS  = 8;
   localparam int COUNT_BITS  = 8;
   localparam int KIND_BITS   = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = 2;
   localparam int LEVEL_BITS  = 3;
   localparam int CAND_COUNT  = 4;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [3:0] {
      T_NORMAL = 4'd0,
      T_SLASH  = 4'd1,
      T_QUOTE  = 4'd2,
      T_QESC   = 4'd3,
      T_LINE   = 4'd4,
      T_BLOCK  = 4'd5,
      T_BSTAR  = 4'd6,
      T_IDENT  = 4'd7,
      T_GAP    = 4'd8,
      C_NORMAL = 4'd9,
      C_SLASH  = 4'd10,
      C_QUOTE  = 4'd11,
      C_QESC   = 4'd12,
      C_LINE   = 4'd13,
      C_BLOCK  = 4'd14,
      C_BSTAR  = 4'd15
   } mode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ARG      = 3'd0,
      KIND_CLOSE    = 3'd1,
      KIND_ABANDON  = 3'd2,
      KIND_OVERFLOW = 3'd3,
      KIND_END      = 3'd4
   } kind_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   typedef struct packed {
      kind_type               kind;
      logic [OFFSET_BITS-1:0] name_start;
      logic [OFFSET_BITS-1:0] name_end;
      logic [OFFSET_BITS-1:0] arg_begin;
      logic [OFFSET_BITS-1:0] arg_end;
      logic [COUNT_BITS-1:0]  arg_number;
      logic [OFFSET_BITS-1:0] call_end;
      logic [COUNT_BITS-1:0]  arg_total;
      logic                   run_last;
   } record_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == 8'h5F);
   endfunction

   function automatic logic is_part(input logic [7:0] c);
      return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39));
   endfunction

endpackage

>>> rtl/call_argument_scanner.sv
// Call argument scanner top level: byte scan state machine and result queue.
// Depends on cas_pkg.
//
//  channel | ports                          | dir | payload
//  --------+--------------------------------+-----+-------------------------------
//  req     | req_valid, req_stall           | in  | req_ch, req_final_byte
//  rsp     | rsp_valid, rsp_stall           | out | rsp_kind .. rsp_run_last
//
// One byte is taken per cycle while req_stall is low; the scan state updates in
// the cycle it is taken. A byte gives zero to three records, written at once
// into a four-entry queue that sends one record per cycle while rsp_stall is
// low, so the output port sets the sustained rate. req_stall is high while the
// queue holds more than one record. Reset is synchronous; a final byte also
// returns the scan state to its reset value for the next text.
module call_argument_scanner (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_ch,
   input  logic                           req_final_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cas_pkg::KIND_BITS-1:0]  rsp_kind,
   output logic [cas_pkg::OFFSET_BITS-1:0] rsp_name_start,
   output logic [cas_pkg::OFFSET_BITS-1:0] rsp_name_end,
   output logic [cas_pkg::OFFSET_BITS-1:0] rsp_arg_begin,
   output logic [cas_pkg::OFFSET_BITS-1:0] rsp_arg_end,
   output logic [cas_pkg::COUNT_BITS-1:0]  rsp_arg_number,
   output logic [cas_pkg::OFFSET_BITS-1:0] rsp_call_end,
   output logic [cas_pkg::COUNT_BITS-1:0]  rsp_arg_total,
   output logic                           rsp_run_last
);

   cas_pkg::mode_type                  mode_ff, mode_in;
   logic [cas_pkg::OFFSET_BITS-1:0]    offset_ff, offset_in;
   logic [cas_pkg::DEPTH_BITS-1:0]     depth_ff, depth_in;
   logic [cas_pkg::OFFSET_BITS-1:0]    ident_start_ff, ident_start_in;
   logic [cas_pkg::OFFSET_BITS-1:0]    ident_stop_ff, ident_stop_in;
   logic [cas_pkg::OFFSET_BITS-1:0]    first_solid_ff, first_solid_in;
   logic [cas_pkg::OFFSET_BITS-1:0]    solid_stop_ff, solid_stop_in;
   logic                               solid_seen_ff, solid_seen_in;
   logic [cas_pkg::COUNT_BITS-1:0]     pieces_ff, pieces_in;

   cas_pkg::record_type                queue_ff [cas_pkg::QUEUE_DEPTH];
   logic [cas_pkg::PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cas_pkg::PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cas_pkg::LEVEL_BITS-1:0]     level_ff, level_in;

   cas_pkg::record_type                cand [cas_pkg::CAND_COUNT];
   logic [cas_pkg::CAND_COUNT-1:0]     cand_valid;
   logic [cas_pkg::PTR_BITS-1:0]       cand_slot [cas_pkg::CAND_COUNT];
   logic [cas_pkg::LEVEL_BITS-1:0]     push_count;

   logic                               req_fire, rsp_fire;
   logic [cas_pkg::OFFSET_BITS-1:0]    next_off;
   logic                               in_call;
   cas_pkg::mode_type                  mode_a, mode_b;
   logic                               delim, do_report, do_paren_ovf, do_close;
   logic                               arg_full;
   logic [cas_pkg::DEPTH_BITS-1:0]     depth_dec;
   logic                               call_open;
   logic [cas_pkg::COUNT_BITS-1:0]     open_total;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = (level_ff > cas_pkg::LEVEL_BITS'(1));
   assign rsp_valid = (level_ff != '0);
   assign next_off  = offset_ff + cas_pkg::OFFSET_BITS'(1);
   assign in_call   = (mode_ff >= cas_pkg::C_NORMAL);
   assign arg_full  = (pieces_ff >= cas_pkg::COUNT_MAX);

   // redirect for bytes that end a slash, an identifier or a gap
   always_comb begin
      mode_a = mode_ff;
      case (mode_ff)
         cas_pkg::T_SLASH: begin
            if (req_ch != cas_pkg::CH_SLASH && req_ch != cas_pkg::CH_STAR)
               mode_a = cas_pkg::T_NORMAL;
         end
         cas_pkg::C_SLASH: begin
            if (req_ch != cas_pkg::CH_SLASH && req_ch != cas_pkg::CH_STAR)
               mode_a = cas_pkg::C_NORMAL;
         end
         cas_pkg::T_IDENT: begin
            if (!cas_pkg::is_part(req_ch)) mode_a = cas_pkg::T_GAP;
         end
         default: begin
            mode_a = mode_ff;
         end
      endcase
      mode_b = mode_a;
      if (mode_a == cas_pkg::T_GAP && !cas_pkg::is_ws(req_ch) && req_ch != cas_pkg::CH_OPEN)
         mode_b = cas_pkg::T_NORMAL;
   end

   // next scan state
   always_comb begin
      mode_in        = mode_b;
      offset_in      = next_off;
      depth_in       = depth_ff;
      ident_start_in = ident_start_ff;
      ident_stop_in  = ident_stop_ff;
      first_solid_in = first_solid_ff;
      solid_stop_in  = solid_stop_ff;
      solid_seen_in  = solid_seen_ff;
      pieces_in      = pieces_ff;
      delim          = 1'b0;
      do_report      = 1'b0;
      do_paren_ovf   = 1'b0;
      do_close       = 1'b0;
      depth_dec      = (depth_ff != '0) ? depth_ff - cas_pkg::DEPTH_BITS'(1) : '0;

      case (mode_b)
         cas_pkg::T_NORMAL: begin
            if (req_ch == cas_pkg::CH_QUOTE) mode_in = cas_pkg::T_QUOTE;
            else if (req_ch == cas_pkg::CH_SLASH) mode_in = cas_pkg::T_SLASH;
            else if (cas_pkg::is_alpha(req_ch)) begin
               ident_start_in = offset_ff;
               ident_stop_in  = next_off;
               mode_in        = cas_pkg::T_IDENT;
            end
         end
         cas_pkg::T_SLASH: begin
            mode_in = (req_ch == cas_pkg::CH_SLASH) ? cas_pkg::T_LINE : cas_pkg::T_BLOCK;
         end
         cas_pkg::C_SLASH: begin
            mode_in = (req_ch == cas_pkg::CH_SLASH) ? cas_pkg::C_LINE : cas_pkg::C_BLOCK;
         end
         cas_pkg::T_QUOTE: begin
            if (req_ch == cas_pkg::CH_BSLASH) mode_in = cas_pkg::T_QESC;
            else if (req_ch == cas_pkg::CH_QUOTE) mode_in = cas_pkg::T_NORMAL;
         end
         cas_pkg::C_QUOTE: begin
            if (req_ch == cas_pkg::CH_BSLASH) mode_in = cas_pkg::C_QESC;
            else if (req_ch == cas_pkg::CH_QUOTE) mode_in = cas_pkg::C_NORMAL;
         end
         cas_pkg::T_QESC: begin
            mode_in = cas_pkg::T_QUOTE;
         end
         cas_pkg::C_QESC: begin
            mode_in = cas_pkg::C_QUOTE;
         end
         cas_pkg::T_LINE: begin
            if (req_ch == cas_pkg::CH_LF) mode_in = cas_pkg::T_NORMAL;
         end
         cas_pkg::C_LINE: begin
            if (req_ch == cas_pkg::CH_LF) mode_in = cas_pkg::C_NORMAL;
         end
         cas_pkg::T_BLOCK: begin
            if (req_ch == cas_pkg::CH_STAR) mode_in = cas_pkg::T_BSTAR;
         end
         cas_pkg::C_BLOCK: begin
            if (req_ch == cas_pkg::CH_STAR) mode_in = cas_pkg::C_BSTAR;
         end
         cas_pkg::T_BSTAR: begin
            if (req_ch == cas_pkg::CH_SLASH) mode_in = cas_pkg::T_NORMAL;
            else if (req_ch != cas_pkg::CH_STAR) mode_in = cas_pkg::T_BLOCK;
         end
         cas_pkg::C_BSTAR: begin
            if (req_ch == cas_pkg::CH_SLASH) mode_in = cas_pkg::C_NORMAL;
            else if (req_ch != cas_pkg::CH_STAR) mode_in = cas_pkg::C_BLOCK;
         end
         cas_pkg::T_IDENT: begin
            ident_stop_in = next_off;
         end
         cas_pkg::T_GAP: begin
            if (req_ch == cas_pkg::CH_OPEN) begin
               mode_in        = cas_pkg::C_NORMAL;
               depth_in       = cas_pkg::DEPTH_BITS'(1);
               solid_seen_in  = 1'b0;
               first_solid_in = '0;
               solid_stop_in  = '0;
               pieces_in      = '0;
            end
         end
         cas_pkg::C_NORMAL: begin
            if (req_ch == cas_pkg::CH_QUOTE) mode_in = cas_pkg::C_QUOTE;
            else if (req_ch == cas_pkg::CH_SLASH) mode_in = cas_pkg::C_SLASH;
            else if (req_ch == cas_pkg::CH_OPEN) begin
               if (depth_ff != cas_pkg::DEPTH_MAX)
                  depth_in = depth_ff + cas_pkg::DEPTH_BITS'(1);
               else
                  do_paren_ovf = 1'b1;
            end else if (req_ch == cas_pkg::CH_CLOSE) begin
               depth_in = depth_dec;
               if (depth_dec == '0) begin
                  delim     = 1'b1;
                  do_report = solid_seen_ff || (pieces_ff != '0);
                  do_close  = 1'b1;
                  mode_in   = cas_pkg::T_NORMAL;
               end
            end else if (req_ch == cas_pkg::CH_COMMA && depth_ff == cas_pkg::DEPTH_BITS'(1)) begin
               delim     = 1'b1;
               do_report = 1'b1;
            end
         end
         default: begin
            mode_in = cas_pkg::T_NORMAL;
         end
      endcase

      if (do_report) begin
         if (!arg_full) pieces_in = pieces_ff + cas_pkg::COUNT_BITS'(1);
         solid_seen_in  = 1'b0;
         first_solid_in = '0;
         solid_stop_in  = '0;
      end

      if (in_call && !delim && !cas_pkg::is_ws(req_ch)) begin
         if (!solid_seen_ff) begin
            first_solid_in = offset_ff;
            solid_seen_in  = 1'b1;
         end
         solid_stop_in = next_off;
      end

      // a call still open after this byte, including one opened by it
      call_open  = (mode_in >= cas_pkg::C_NORMAL);
      open_total = pieces_in;

      if (req_final_byte) begin
         mode_in        = cas_pkg::T_NORMAL;
         offset_in      = '0;
         depth_in       = '0;
         ident_start_in = '0;
         ident_stop_in  = '0;
         first_solid_in = '0;
         solid_stop_in  = '0;
         solid_seen_in  = 1'b0;
         pieces_in      = '0;
      end
   end

   // candidate records: argument or overflow, close, abandon, end of source
   always_comb begin
      for (int i = 0; i < cas_pkg::CAND_COUNT; i++) begin
         cand[i] = '0;
      end

      cand_valid[0]      = do_paren_ovf || do_report;
      cand[0].name_start = ident_start_ff;
      cand[0].name_end   = ident_stop_ff;
      cand[0].arg_number = pieces_ff;
      if (do_paren_ovf || arg_full) begin
         cand[0].kind = cas_pkg::KIND_OVERFLOW;
      end else begin
         cand[0].kind      = cas_pkg::KIND_ARG;
         cand[0].arg_begin = solid_seen_ff ? first_solid_ff : offset_ff;
         cand[0].arg_end   = solid_seen_ff ? solid_stop_ff : offset_ff;
      end

      cand_valid[1]      = do_close;
      cand[1].kind       = cas_pkg::KIND_CLOSE;
      cand[1].name_start = ident_start_ff;
      cand[1].name_end   = ident_stop_ff;
      cand[1].call_end   = next_off;
      cand[1].arg_total  = do_report && !arg_full ? pieces_ff + cas_pkg::COUNT_BITS'(1)
                                                  : pieces_ff;

      cand_valid[2]      = req_final_byte && call_open;
      cand[2].kind       = cas_pkg::KIND_ABANDON;
      cand[2].name_start = ident_start_ff;
      cand[2].name_end   = ident_stop_ff;
      cand[2].arg_total  = open_total;

      cand_valid[3]      = req_final_byte;
      cand[3].kind       = cas_pkg::KIND_END;

      for (int i = 0; i < cas_pkg::CAND_COUNT; i++) begin
         cand[i].run_last = cand_valid[i] && ((cand_valid >> (i + 1)) == '0);
      end

      cand_slot[0] = wr_ptr_ff;
      for (int i = 1; i < cas_pkg::CAND_COUNT; i++) begin
         cand_slot[i] = cand_slot[i-1] + cas_pkg::PTR_BITS'(cand_valid[i-1]);
      end
      push_count = cas_pkg::LEVEL_BITS'($countones(cand_valid));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + cas_pkg::PTR_BITS'(push_count);
         level_in  = level_in + push_count;
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + cas_pkg::PTR_BITS'(1);
         level_in  = level_in - cas_pkg::LEVEL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= cas_pkg::T_NORMAL;
         offset_ff      <= '0;
         depth_ff       <= '0;
         ident_start_ff <= '0;
         ident_stop_ff  <= '0;
         first_solid_ff <= '0;
         solid_stop_ff  <= '0;
         solid_seen_ff  <= 1'b0;
         pieces_ff      <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         level_ff       <= '0;
      end else begin
         if (req_fire) begin
            mode_ff        <= mode_in;
            offset_ff      <= offset_in;
            depth_ff       <= depth_in;
            ident_start_ff <= ident_start_in;
            ident_stop_ff  <= ident_stop_in;
            first_solid_ff <= first_solid_in;
            solid_stop_ff  <= solid_stop_in;
            solid_seen_ff  <= solid_seen_in;
            pieces_ff      <= pieces_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < cas_pkg::CAND_COUNT; i++) begin
            if (cand_valid[i]) queue_ff[cand_slot[i]] <= cand[i];
         end
      end
   end

   assign rsp_kind       = queue_ff[rd_ptr_ff].kind;
   assign rsp_name_start = queue_ff[rd_ptr_ff].name_start;
   assign rsp_name_end   = queue_ff[rd_ptr_ff].name_end;
   assign rsp_arg_begin  = queue_ff[rd_ptr_ff].arg_begin;
   assign rsp_arg_end    = queue_ff[rd_ptr_ff].arg_end;
   assign rsp_arg_number = queue_ff[rd_ptr_ff].arg_number;
   assign rsp_call_end   = queue_ff[rd_ptr_ff].call_end;
   assign rsp_arg_total  = queue_ff[rd_ptr_ff].arg_total;
   assign rsp_run_last   = queue_ff[rd_ptr_ff].run_last;

endmodule

>>> rtl/cas_checker.sv
// Port checker for the call argument scanner, bound to the top level.
// Depends on cas_pkg and rtl/call_argument_scanner.sv.
module cas_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [7:0]                      req_ch,
   input logic                            req_final_byte,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [cas_pkg::KIND_BITS-1:0]   rsp_kind,
   input logic [cas_pkg::OFFSET_BITS-1:0] rsp_name_start,
   input logic [cas_pkg::OFFSET_BITS-1:0] rsp_name_end,
   input logic [cas_pkg::OFFSET_BITS-1:0] rsp_arg_begin,
   input logic [cas_pkg::OFFSET_BITS-1:0] rsp_arg_end,
   input logic [cas_pkg::COUNT_BITS-1:0]  rsp_arg_number,
   input logic [cas_pkg::OFFSET_BITS-1:0] rsp_call_end,
   input logic [cas_pkg::COUNT_BITS-1:0]  rsp_arg_total,
   input logic                            rsp_run_last
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_ch) && $stable(req_final_byte))
      else $error("stalled input item changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_arg_end)
                                 && $stable(rsp_run_last))
      else $error("stalled result item changed");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == cas_pkg::KIND_END |-> rsp_run_last)
      else $error("end of source item not last of its byte");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == cas_pkg::KIND_END |->
         rsp_name_start == '0 && rsp_name_end == '0 && rsp_arg_total == '0
         && rsp_call_end == '0 && rsp_arg_number == '0)
      else $error("end of source item carries data");

   a_close_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == cas_pkg::KIND_CLOSE |->
         rsp_arg_begin == '0 && rsp_arg_end == '0 && rsp_arg_number == '0)
      else $error("close item carries argument fields");

endmodule

bind call_argument_scanner cas_checker u_cas_checker (.*);
